FILE: rtl/core/hmns_pkg.sv
// Shared constants for the height map normal stencil.
`default_nettype none

package hmns_pkg;

	localparam int MAP_SIZE = 1024;
	localparam int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
	localparam int POS_W    = 12;
	localparam int NRM_W    = 11;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(MAP_SIZE - 1);
	localparam logic [POS_W-1:0] FINAL_CTR = POS_W'(MAP_SIZE - 2);
	localparam logic [2:0]       NORMAL_Y  = 3'd5;

	typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

`default_nettype wire

FILE: rtl/core/height_map_normal_stencil.sv
// Height map normal stencil: 3x3 window over two line buffers, one sample per cycle.
//
// Takes one 8-bit height sample per cycle in raster order (column fastest) and, for every
// interior sample, gives the unnormalized surface normal once the sample one row below and one
// column right has arrived. A sample is accepted in every cycle unless stage one holds one and a
// finished normal is held at the output under stall; the sample that completes a window is
// registered in stage one, and its normal is registered at the output when stage one advances.
// The rate is set by the two line buffers, each read and written once per cycle, and by a
// nine-register sliding window. frame_start restarts the position at row 0, column 0; border
// samples give no normal, and last marks the normal of the final interior sample of the map.
`default_nettype none

module height_map_normal_stencil
	import hmns_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       height,
	input  wire logic             frame_start,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic signed [10:0]    normal_x,
	output logic [2:0]            normal_y,
	output logic signed [10:0]    normal_z,
	output logic [11:0]           center_row,
	output logic [11:0]           center_col,
	output logic                  last
);

	logic [7:0] prev_mem  [MAP_SIZE];
	logic [7:0] prev2_mem [MAP_SIZE];

	logic [POS_W-1:0]  row_q, col_q;
	logic [POS_W-1:0]  r_in, c_in;
	logic [ADDR_W-1:0] idx_in;
	logic              in_acc;

	logic              valid_s1;
	logic [7:0]        h_s1;
	logic [POS_W-1:0]  r_s1, c_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              fwd_s1;
	logic [7:0]        fwd_val_s1;
	logic [7:0]        rd_prev_s1, rd_prev2_s1;
	logic [7:0]        up1, up2;
	logic              adv;
	logic              res_s1, last_s1;

	logic [7:0] win_q [9];

	nrm_t ext_cp, ext_b, ext_d, ext_h0, ext_a, ext_e, ext_f;
	nrm_t nx, nz;

	assign r_in   = frame_start ? '0 : row_q;
	assign c_in   = frame_start ? '0 : col_q;
	assign idx_in = c_in[ADDR_W-1:0];

	assign adv      = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	assign up1 = rd_prev_s1;
	assign up2 = fwd_s1 ? fwd_val_s1 : rd_prev2_s1;

	assign res_s1  = (r_s1 >= POS_W'(2)) && (c_s1 >= POS_W'(2));
	assign last_s1 = (r_s1 == LAST_POS) && (c_s1 == LAST_POS);

	// window taps after the shift: cp=(r-1,c-1), b=(r-1,c), d=(r,c-1), h0, a, e, f
	assign ext_cp = nrm_t'({3'b000, win_q[1]});
	assign ext_b  = nrm_t'({3'b000, win_q[2]});
	assign ext_d  = nrm_t'({3'b000, win_q[4]});
	assign ext_h0 = nrm_t'({3'b000, win_q[5]});
	assign ext_a  = nrm_t'({3'b000, up1});
	assign ext_e  = nrm_t'({3'b000, win_q[8]});
	assign ext_f  = nrm_t'({3'b000, h_s1});

	assign nx = (ext_b <<< 1) + ext_cp - ext_d - (ext_e <<< 1);
	assign nz = ext_cp + (ext_d <<< 1) + ext_e - ext_a - ext_b - ext_f - ext_h0;

	assign normal_y = NORMAL_Y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (c_in == LAST_POS) begin
				col_q <= '0;
				row_q <= (r_in == LAST_POS) ? '0 : r_in + POS_W'(1);
			end else begin
				col_q <= c_in + POS_W'(1);
				row_q <= r_in;
			end
		end
	end

	// line buffers: previous row written on accept, older row written from stage one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_mem[idx_in] <= height;
			rd_prev_s1       <= prev_mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			prev2_mem[idx_s1] <= up1;
		if (in_acc)
			rd_prev2_s1 <= prev2_mem[idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			h_s1       <= height;
			r_s1       <= r_in;
			c_s1       <= c_in;
			idx_s1     <= idx_in;
			fwd_s1     <= valid_s1 && (idx_s1 == idx_in);
			fwd_val_s1 <= up1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++)
				win_q[k] <= '0;
		end else if (adv) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]     <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
			end
			win_q[2] <= up2;
			win_q[5] <= up1;
			win_q[8] <= h_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res_s1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s1) begin
			normal_x   <= nx;
			normal_z   <= nz;
			center_row <= r_s1 - POS_W'(1);
			center_col <= c_s1 - POS_W'(1);
			last       <= last_s1;
		end
	end

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> center_row == FINAL_CTR && center_col == FINAL_CTR)
		else $error("last flag on a normal that is not the final one");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> center_row != '0 && center_col != '0
			&& center_row < LAST_POS && center_col < LAST_POS)
		else $error("normal given for a border sample");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with no blocked result");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_s1 |=> out_valid)
		else $error("interior sample advanced without a result");

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && valid_s1 && adv && (idx_s1 == idx_in) |=> fwd_s1)
		else $error("older row bypass missed on equal column");

endmodule

`default_nettype wire

FILE: tb/height_map_normal_stencil_tb.sv
// Self-checking testbench for the height map normal stencil, with its own window predictor.
`timescale 1ns / 100ps

module height_map_normal_stencil_tb
	import hmns_pkg::*;
();

	localparam int EXT_COLS = 48;

	typedef struct {
		nrm_t        nx;
		logic [2:0]  ny;
		nrm_t        nz;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
	} normal_rec_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         height;
	logic               frame_start;
	logic               out_valid;
	logic               out_stall;
	logic signed [10:0] normal_x;
	logic [2:0]         normal_y;
	logic signed [10:0] normal_z;
	logic [11:0]        center_row;
	logic [11:0]        center_col;
	logic               last;

	logic [7:0]  prev_row_buf [MAP_SIZE];
	logic [7:0]  prev2_row_buf [MAP_SIZE];
	logic [7:0]  window [9];
	int unsigned next_row;
	int unsigned next_col;

	normal_rec_t normals_due [$];
	int          mismatches;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          tx_calm;
	int          long_hold;

	height_map_normal_stencil uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.height      (height),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.center_row  (center_row),
		.center_col  (center_col),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL height_map_normal_stencil");
		$finish;
	end

	function automatic void predict_normal(input logic [7:0] h, input logic fs);
		int unsigned r;
		int unsigned c;
		logic [7:0]  above;
		logic [7:0]  above2;
		int          cp, b, d, h0, a, e, f;
		normal_rec_t n;
		r = fs ? 0 : next_row;
		c = fs ? 0 : next_col;
		above = prev_row_buf[c];
		above2 = prev2_row_buf[c];
		prev2_row_buf[c] = above;
		prev_row_buf[c] = h;
		for (int k = 0; k < 3; k++) begin
			window[k*3] = window[k*3+1];
			window[k*3+1] = window[k*3+2];
		end
		window[2] = above2;
		window[5] = above;
		window[8] = h;
		if (c + 1 >= MAP_SIZE) begin
			next_col = 0;
			next_row = (r + 1 >= MAP_SIZE) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
		if (r >= 2 && c >= 2) begin
			cp = window[0];
			b = window[1];
			d = window[3];
			h0 = window[4];
			a = window[5];
			e = window[7];
			f = window[8];
			n.nx = nrm_t'(2*b + cp - d - 2*e);
			n.ny = NORMAL_Y;
			n.nz = nrm_t'(cp + 2*d + e - a - b - f - h0);
			n.row = 12'(r - 1);
			n.col = 12'(c - 1);
			n.last = (r == MAP_SIZE - 1) && (c == MAP_SIZE - 1);
			normals_due.push_back(n);
		end
	endfunction

	function automatic logic [7:0] rand_height();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// first columns of rows 0 to 2 drive both normal components to their extremes
	function automatic logic [7:0] extreme_height(input int r, input int c);
		bit hi;
		if (c >= EXT_COLS)
			return rand_height();
		case (c / 12)
			0: hi = (r == 0);
			1: hi = (r != 0);
			2: hi = (r == 2) ? (c % 3 == 1) : (c % 3 == 0);
			default: hi = (r == 2) ? (c % 3 != 1) : (c % 3 != 0);
		endcase
		return hi ? 8'hFF : 8'h00;
	endfunction

	task automatic send_height(input logic [7:0] h, input logic fs);
		int gap;
		if (tx_calm != 0) begin
			tx_calm--;
		end else if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else if (tx_idle_on && $urandom_range(0, 15) == 0) begin
			tx_calm = $urandom_range(20, 200);
		end
		height <= h;
		frame_start <= fs;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_normal(h, fs);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (normals_due.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string label, input int want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	// receiver hold-off
	initial begin : receiver_stall
		int left;
		bit hold;
		left = 0;
		hold = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold != 0) begin
				hold = 1'b1;
				left = long_hold;
				long_hold = 0;
			end else if (left != 0) begin
				left--;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				hold = 1'b1;
				left = $urandom_range(0, 12);
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				hold = 1'b0;
				left = $urandom_range(20, 150);
			end else begin
				hold = 1'b0;
			end
			out_stall <= hold;
		end
	end

	always @(posedge clk) begin : check_normals
		normal_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (normals_due.size() == 0) begin
				$display("%0t unexpected normal: expected none actual row %0d col %0d",
					$time, center_row, center_col);
				mismatches++;
			end else begin
				want = normals_due.pop_front();
				check_field("normal_x", want.nx, normal_x);
				check_field("normal_y", want.ny, normal_y);
				check_field("normal_z", want.nz, normal_z);
				check_field("center_row", want.row, center_row);
				check_field("center_col", want.col, center_col);
				check_field("last", want.last, last);
			end
		end
	end

	// border rows of a map begun without frame_start give no normal
	task automatic test_no_frame_start();
		for (int i = 0; i < 2*MAP_SIZE; i++)
			send_height(extreme_height(i / MAP_SIZE, i % MAP_SIZE), 1'b0);
		wait_drained();
	endtask

	task automatic test_extremes();
		for (int c = 0; c < EXT_COLS; c++)
			send_height(extreme_height(2, c), 1'b0);
		wait_drained();
	endtask

	task automatic test_pressure();
		tx_idle_on = 1'b0;
		for (int i = 0; i < 100; i++) begin
			if (i == 8)
				long_hold = 300;
			send_height(rand_height(), 1'b0);
		end
		wait_drained();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_back_to_back();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 150; i++)
			send_height(rand_height(), 1'b0);
		wait_drained();
	endtask

	// restart in mid-map, twice in a row and once more later
	task automatic test_restart();
		for (int i = 0; i < 60; i++)
			send_height(rand_height(), i == 0 || i == 1 || i == 30);
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		height <= 8'h00;
		frame_start <= 1'b0;
		mismatches = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		tx_calm = 0;
		long_hold = 0;
		next_row = 0;
		next_col = 0;
		for (int k = 0; k < 9; k++) window[k] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_frame_start();
		test_extremes();
		test_pressure();
		test_back_to_back();
		test_restart();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && normals_due.size() == 0)
			$display("PASS height_map_normal_stencil");
		else
			$display("FAIL height_map_normal_stencil");
		$finish;
	end

endmodule
